// File: rtl/indexed_insert_delete_array_macros.svh
// Assertion macros shared by the indexed insert/delete array RTL.
`ifndef INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH
`define INDEXED_INSERT_DELETE_ARRAY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIDA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIDA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/iida_pkg.sv
// Shared types and codes of the indexed insert/delete array.
package iida_pkg;

   typedef enum logic [2:0] {
      CMD_APPEND  = 3'd0,
      CMD_INSERT  = 3'd1,
      CMD_READ    = 3'd2,
      CMD_REMOVE  = 3'd3,
      CMD_REPLACE = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   localparam int CmdBits    = 3;
   localparam int PosBits    = 7;
   localparam int DataBits   = 32;
   localparam int StatusBits = 2;
   localparam int CountBits  = 7;

   // Operation broadcast to every cell of the chain for one transfer.
   typedef struct packed {
      logic load;
      logic shift_up;
      logic shift_down;
      logic write;
      logic read;
   } cell_ctrl_type;

endpackage

// File: rtl/iida_cell.sv
// One storage cell of the array chain, holding the entry at a fixed index.
module iida_cell
   import iida_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int IDX_W     = 6,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [IDX_W-1:0]     target,
   input  logic [WORD_BITS-1:0] new_word,
   input  logic [WORD_BITS-1:0] left_word,
   input  logic [WORD_BITS-1:0] right_word,
   output logic [WORD_BITS-1:0] word_out,
   output logic [WORD_BITS-1:0] rd_out
);

   localparam logic [IDX_W-1:0] MyIndex = IDX_W'(INDEX);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic [WORD_BITS-1:0] rd_ff;
   logic [WORD_BITS-1:0] rd_in;

   always_comb begin
      word_in = word_ff;
      rd_in   = rd_ff;
      if (ctrl.load) begin
         if (ctrl.shift_up && (MyIndex > target)) begin
            word_in = left_word;
         end else if (ctrl.shift_down && (MyIndex >= target)) begin
            word_in = right_word;
         end else if (ctrl.write && (MyIndex == target)) begin
            word_in = new_word;
         end
         rd_in = (ctrl.read && (MyIndex == target)) ? word_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rd_ff   <= rd_in;
   end

   assign word_out = word_ff;
   assign rd_out   = rd_ff;

endmodule

// File: rtl/iida_or_tree.sv
// Balanced OR tree that gathers the read words of all cells into one word.
module iida_or_tree
   import iida_pkg::*;
#(
   parameter int N = 64,
   parameter int W = 32
) (
   input  logic [W-1:0] leaf [N],
   output logic [W-1:0] root
);

   localparam int Levels = (N > 1) ? $clog2(N) : 1;
   localparam int Leaves = 1 << Levels;

   logic [W-1:0] node [2*Leaves-1];

   for (genvar k = 0; k < Leaves; k++) begin : g_leaf
      if (k < N) begin : g_used
         assign node[Leaves-1+k] = leaf[k];
      end else begin : g_pad
         assign node[Leaves-1+k] = '0;
      end
   end

   for (genvar j = 0; j < Leaves - 1; j++) begin : g_node
      assign node[j] = node[2*j+1] | node[2*j+2];
   end

   assign root = node[0];

endmodule

// File: rtl/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete word array built as a chain of cells.
//
//   Channel  Direction  Fields (tdata, lowest bit first)
//   req      in         cmd[2:0], position[9:3], word_in[41:10]
//   rsp      out        word_out[31:0], status[33:32], fill_count[40:34]
//
// Every cell updates in the cycle its command transfer is taken, so one
// command can be accepted each cycle while responses are not stalled. The
// read word passes a cell register, the OR tree and the response register.
// Reset clears the fill count and the pipeline valids; entries stay unknown.
// A stalled response holds the stage behind it and then the request side.
module indexed_insert_delete_array
   import iida_pkg::*;
#(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // cmd, position, word_in, zero padding
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // word_out, status, fill_count, zero padding
);

   `include "indexed_insert_delete_array_macros.svh"

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int IdxW = $clog2(CAPACITY);
   localparam int CmpW = (CntW > PosBits) ? CntW : PosBits;
   localparam int RspBits = DataBits + StatusBits + CountBits;

   cmd_type               req_cmd;
   logic [PosBits-1:0]    req_position;
   logic [DataBits-1:0]   req_word_in;
   logic                  req_accept;

   logic [CntW-1:0]       used_ff;
   logic [CntW-1:0]       used_in;
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   status_type            s1_status_ff;
   status_type            s1_status_in;
   logic [CntW-1:0]       s1_count_ff;
   logic [CntW-1:0]       s1_count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DataBits-1:0]   rsp_word_ff;
   logic [DataBits-1:0]   rsp_word_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;
   logic [CountBits-1:0]  rsp_count_ff;
   logic [CountBits-1:0]  rsp_count_in;

   logic                  s1_move;
   logic                  full;
   logic [CmpW-1:0]       pos_cmp;
   logic [CmpW-1:0]       used_cmp;
   status_type            dec_status;
   logic [CntW-1:0]       dec_used;
   logic [CmpW-1:0]       dec_target;
   cell_ctrl_type         dec_ctrl;
   cell_ctrl_type         cell_ctrl;
   logic [IdxW-1:0]       cell_target;
   logic [WORD_BITS-1:0]  store_word;
   logic [WORD_BITS-1:0]  cell_word [CAPACITY];
   logic [WORD_BITS-1:0]  cell_rd [CAPACITY];
   logic [WORD_BITS-1:0]  tree_root;

   assign req_cmd      = cmd_type'(req_tdata[CmdBits-1:0]);
   assign req_position = req_tdata[CmdBits+PosBits-1:CmdBits];
   assign req_word_in  = req_tdata[CmdBits+PosBits+DataBits-1:CmdBits+PosBits];

   assign s1_move    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_accept = req_tvalid && req_tready;

   assign full       = (used_ff == CntW'(CAPACITY));
   assign pos_cmp    = CmpW'(req_position);
   assign used_cmp   = CmpW'(used_ff);
   assign store_word = WORD_BITS'(req_word_in);

   always_comb begin
      dec_status = STATUS_OK;
      dec_used   = used_ff;
      dec_target = pos_cmp;
      dec_ctrl   = '0;
      case (req_cmd)
         CMD_APPEND: begin
            if (full) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_ctrl.write = 1'b1;
               dec_target     = used_cmp;
               dec_used       = used_ff + CntW'(1);
            end
         end
         CMD_INSERT: begin
            if (pos_cmp > used_cmp) begin
               dec_status = STATUS_RANGE;
            end else if (full) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_ctrl.shift_up = 1'b1;
               dec_ctrl.write    = 1'b1;
               dec_used          = used_ff + CntW'(1);
            end
         end
         CMD_READ: begin
            if (pos_cmp >= used_cmp) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_ctrl.read = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (pos_cmp >= used_cmp) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_ctrl.shift_down = 1'b1;
               dec_used            = used_ff - CntW'(1);
            end
         end
         CMD_REPLACE: begin
            if (pos_cmp >= used_cmp) begin
               dec_status = STATUS_RANGE;
            end else begin
               dec_ctrl.write = 1'b1;
            end
         end
         default: begin
            dec_status = STATUS_RANGE;
         end
      endcase
   end

   always_comb begin
      cell_ctrl      = dec_ctrl;
      cell_ctrl.load = req_accept;
   end

   assign cell_target = dec_target[IdxW-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_word;
      logic [WORD_BITS-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = cell_word[i];
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end

      iida_cell #(
         .WORD_BITS (WORD_BITS),
         .IDX_W     (IdxW),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .target     (cell_target),
         .new_word   (store_word),
         .left_word  (left_word),
         .right_word (right_word),
         .word_out   (cell_word[i]),
         .rd_out     (cell_rd[i])
      );
   end

   iida_or_tree #(
      .N (CAPACITY),
      .W (WORD_BITS)
   ) u_or_tree (
      .leaf (cell_rd),
      .root (tree_root)
   );

   always_comb begin
      used_in      = used_ff;
      s1_valid_in  = s1_valid_ff;
      s1_status_in = s1_status_ff;
      s1_count_in  = s1_count_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         used_in      = dec_used;
         s1_valid_in  = 1'b1;
         s1_status_in = dec_status;
         s1_count_in  = dec_used;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = DataBits'(tree_root);
         rsp_status_in = s1_status_ff;
         rsp_count_in  = CountBits'(s1_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff  <= s1_status_in;
      s1_count_ff   <= s1_count_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(48-RspBits){1'b0}}, rsp_count_ff, rsp_status_ff, rsp_word_ff};

   `IIDA_ASSERT_SAME(a_used_bound, 1'b1, used_ff <= CntW'(CAPACITY), "Fill count exceeds capacity.")
   `IIDA_ASSERT_NEXT(a_used_stable, !req_accept, $stable(used_ff), "Fill count moved without a transfer.")
   `IIDA_ASSERT_NEXT(a_full_status, req_accept && (req_cmd == CMD_APPEND) && full, s1_status_ff == STATUS_FULL, "Append to a full array was not refused.")
   `IIDA_ASSERT_NEXT(a_stage_move, s1_move, rsp_valid_ff, "Response register missed a finished command.")

endmodule

// File: tb/tb_top.sv
// Self-checking stream testbench that predicts every response of the insert/delete array.
module tb_top;
   import iida_pkg::*;

   localparam int Capacity = 64;
   localparam logic [CmdBits-1:0] CmdUnusedFirst = 3'd5;
   localparam logic [CmdBits-1:0] CmdUnusedMiddle = 3'd6;
   localparam logic [CmdBits-1:0] CmdUnusedLast = 3'd7;
   localparam int WatchdogLimit = 4000;
   localparam int LongHoldCycles = 400;
   localparam int LongHoldAfter = 700;
   localparam int ItemsPerHalf = 900;
   localparam int SettleCycles = 10;
   localparam int MaxReported = 10;

   typedef enum int {
      PHASE_GROW,
      PHASE_SHRINK,
      PHASE_MIXED
   } phase_type;

   typedef struct {
      logic [CmdBits-1:0]  cmd;
      logic [PosBits-1:0]  position;
      logic [DataBits-1:0] word;
   } command_type;

   typedef struct {
      logic [DataBits-1:0]   word;
      logic [StatusBits-1:0] status;
      logic [CountBits-1:0]  fill;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // cmd, position, word_in, zero padding
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // word_out, status, fill_count, zero padding

   logic [DataBits-1:0] shadow_words [Capacity];
   int                  shadow_fill = 0;
   int                  planned_fill = 0;

   command_type  pending_commands [$];
   response_type expected_responses [$];
   command_type  offered;

   int send_gap = 0;
   int send_calm = 0;
   int recv_gap = 0;
   int recv_calm = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int responses_seen = 0;
   int error_count = 0;
   int idle_cycles = 0;

   indexed_insert_delete_array u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic response_type apply_array_command(command_type c);
      response_type r;
      int i;
      r.word = '0;
      r.status = STATUS_OK;
      case (c.cmd)
         CMD_APPEND: begin
            if (shadow_fill >= Capacity) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_words[shadow_fill] = c.word;
               shadow_fill++;
            end
         end
         CMD_INSERT: begin
            if (int'(c.position) > shadow_fill) begin
               r.status = STATUS_RANGE;
            end else if (shadow_fill >= Capacity) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = shadow_fill; i > int'(c.position); i--)
                  shadow_words[i] = shadow_words[i - 1];
               shadow_words[c.position] = c.word;
               shadow_fill++;
            end
         end
         CMD_READ: begin
            if (int'(c.position) >= shadow_fill) r.status = STATUS_RANGE;
            else r.word = shadow_words[c.position];
         end
         CMD_REMOVE: begin
            if (int'(c.position) >= shadow_fill) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = int'(c.position); i + 1 < shadow_fill; i++)
                  shadow_words[i] = shadow_words[i + 1];
               shadow_fill--;
            end
         end
         CMD_REPLACE: begin
            if (int'(c.position) >= shadow_fill) r.status = STATUS_RANGE;
            else shadow_words[c.position] = c.word;
         end
         default: begin
            r.status = STATUS_RANGE;
         end
      endcase
      r.fill = CountBits'(shadow_fill);
      return r;
   endfunction

   // Only the fill count is tracked here, so that positions can aim at the live range.
   function automatic void queue_command(command_type c);
      case (c.cmd)
         CMD_APPEND: if (planned_fill < Capacity) planned_fill++;
         CMD_INSERT: if (int'(c.position) <= planned_fill && planned_fill < Capacity)
            planned_fill++;
         CMD_REMOVE: if (int'(c.position) < planned_fill) planned_fill--;
         default: ;
      endcase
      pending_commands = {pending_commands, c};
   endfunction

   function automatic command_type make_command(phase_type kind);
      command_type c;
      logic [CmdBits-1:0] odd_cmd;
      int r;
      int p;
      odd_cmd = CmdBits'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_GROW:
            c.cmd = r < 45 ? CMD_APPEND : r < 85 ? CMD_INSERT : r < 92 ? CMD_READ :
                    r < 96 ? CMD_REPLACE : r < 98 ? CMD_REMOVE : odd_cmd;
         PHASE_SHRINK:
            c.cmd = r < 4 ? CMD_APPEND : r < 8 ? CMD_INSERT : r < 20 ? CMD_READ :
                    r < 30 ? CMD_REPLACE : r < 96 ? CMD_REMOVE : odd_cmd;
         default:
            c.cmd = r < 20 ? CMD_APPEND : r < 40 ? CMD_INSERT : r < 60 ? CMD_READ :
                    r < 75 ? CMD_REMOVE : r < 92 ? CMD_REPLACE : odd_cmd;
      endcase
      r = $urandom_range(0, 99);
      if (r < 70) p = $urandom_range(0, planned_fill);
      else if (r < 80) p = planned_fill;
      else if (r < 88) p = planned_fill == 0 ? 0 : planned_fill - 1;
      else p = $urandom_range(0, 127);
      c.position = PosBits'(p);
      r = $urandom_range(0, 19);
      c.word = r == 0 ? '0 : r == 1 ? '1 : DataBits'($urandom);
      return c;
   endfunction

   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_until_drained();
      while (pending_commands.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= MaxReported) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_responses = {expected_responses, apply_array_command(offered)};
         if (send_gap == 0 && pending_commands.size() != 0) begin
            offered = pending_commands.pop_front();
            req_tdata <= 48'({offered.word, offered.position, offered.cmd});
            req_tvalid <= 1'b1;
            send_gap = pick_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end
      end
   end

   always @(posedge clock) begin
      response_type got;
      response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.word = rsp_tdata[31:0];
            got.status = rsp_tdata[33:32];
            got.fill = rsp_tdata[40:34];
            responses_seen++;
            if (expected_responses.size() == 0) begin
               flag_error($sformatf("response with nothing expected: word %h status %0d fill %0d",
                                    got.word, got.status, got.fill));
            end else begin
               want = expected_responses.pop_front();
               if (got.word !== want.word || got.status !== want.status ||
                   got.fill !== want.fill)
                  flag_error($sformatf(
                     "transfer %0d: expected word %h status %0d fill %0d, got %h %0d %0d",
                     responses_seen, want.word, want.status, want.fill,
                     got.word, got.status, got.fill));
            end
         end
         if (responses_seen == LongHoldAfter && !long_hold_done) begin
            hold_left = LongHoldCycles;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (recv_gap > 0) begin
            rsp_tready <= 1'b0;
            recv_gap--;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap(recv_calm);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int left;
      int chunk;
      phase_type kind;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty array, boundary positions, extreme words and the unused command codes.
      queue_command('{CMD_READ, 7'd0, 32'h0000_0000});
      queue_command('{CMD_REMOVE, 7'd0, 32'h0000_0000});
      queue_command('{CMD_REPLACE, 7'd0, 32'hFFFF_FFFF});
      queue_command('{CMD_INSERT, 7'd1, 32'h1111_1111});
      queue_command('{CMD_INSERT, 7'd0, 32'hFFFF_FFFF});
      queue_command('{CMD_APPEND, 7'd0, 32'h0000_0000});
      queue_command('{CMD_APPEND, 7'd0, 32'h5555_AAAA});
      queue_command('{CMD_INSERT, 7'd3, 32'hA5A5_A5A5});
      queue_command('{CMD_INSERT, 7'd1, 32'h0000_1234});
      queue_command('{CMD_READ, 7'd4, 32'h0000_0000});
      queue_command('{CMD_READ, 7'd0, 32'h0000_0000});
      queue_command('{CMD_READ, 7'd5, 32'h0000_0000});
      queue_command('{CMD_REPLACE, 7'd2, 32'hDEAD_BEEF});
      queue_command('{CMD_READ, 7'd2, 32'h0000_0000});
      queue_command('{CMD_REMOVE, 7'd0, 32'h0000_0000});
      queue_command('{CMD_REMOVE, 7'd3, 32'h0000_0000});
      queue_command('{CMD_READ, 7'd0, 32'h0000_0000});
      queue_command('{CMD_READ, 7'd127, 32'h0000_0000});
      queue_command('{CMD_INSERT, 7'd127, 32'h8000_0001});
      queue_command('{CmdUnusedFirst, 7'd0, 32'hFFFF_FFFF});
      queue_command('{CmdUnusedMiddle, 7'd1, 32'h0000_0000});
      queue_command('{CmdUnusedLast, 7'd127, 32'h7FFF_FFFE});
      queue_command('{CMD_REMOVE, 7'd64, 32'h0000_0000});
      wait_until_drained();

      for (int half = 0; half < 2; half++) begin
         left = ItemsPerHalf;
         while (left > 0) begin
            kind = phase_type'($urandom_range(PHASE_GROW, PHASE_MIXED));
            chunk = $urandom_range(40, 160);
            if (chunk > left) chunk = left;
            repeat (chunk) begin
               queue_command(make_command(kind));
               left--;
            end
         end
         wait_until_drained();
      end

      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
